/* src/ws_ring_pkg.sv */
// Shared types, command codes and helpers for the LED ring frame driver.
package ws_ring_pkg;

	localparam int BPP   = 24;
	localparam int BIT_W = 5;

	localparam logic [2:0] CMD_SET     = 3'd0;
	localparam logic [2:0] CMD_RING    = 3'd1;
	localparam logic [2:0] CMD_WHEEL   = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_BREATHE = 3'd4;
	localparam logic [2:0] CMD_TICK    = 3'd5;

	localparam logic REG_HIGH_DUTY = 1'b0;
	localparam logic REG_LOW_DUTY  = 1'b1;

	localparam logic [1:0] CH_GREEN = 2'd2;
	localparam logic [1:0] CH_BLUE  = 2'd3;

	localparam logic [7:0] RAMP_LO  = 8'd85;
	localparam logic [7:0] RAMP_HI  = 8'd170;
	localparam logic [7:0] RAMP_MAX = 8'd255;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  pixel_index;
		logic [23:0] color;
		logic [7:0]  level;
		logic [1:0]  channel;
	} in_t;

	typedef struct packed {
		logic [15:0] duty;
		logic        frame_last;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_READ,
		ST_SHIFT,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic            load;
		logic [23:0]     word;
		logic [BIT_W-1:0] count;
	} bs_req_t;

	typedef struct packed {
		logic done;
		logic bit_val;
	} bs_rsp_t;

	// Three-phase breathing ramp placed on the chosen channel.
	function automatic logic [23:0] ramp_color(input logic [7:0] level,
		input logic [1:0] channel);
		logic [7:0] t;
		logic [9:0] prod;
		logic [7:0] v;
		t = RAMP_MAX - level;
		if (t < RAMP_LO) begin
			prod = 10'(t) * 10'd3;
			v = prod[7:0];
		end else if (t < RAMP_HI) begin
			v = RAMP_MAX;
		end else begin
			prod = 10'(RAMP_MAX) - 10'(t - RAMP_HI) * 10'd3;
			v = prod[7:0];
		end
		unique case (channel)
			CH_GREEN: ramp_color = {v, 16'd0};
			CH_BLUE:  ramp_color = {16'd0, v};
			default:  ramp_color = {8'd0, v, 8'd0};
		endcase
	endfunction

endpackage

/* src/ws2812_ring_frame_driver_core.sv */
// Top level of the LED ring frame driver: command decode, frame store sweeps and slot output.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall  | ws_ring_pkg::in_t
//  out     | output    | out_valid / out_stall| ws_ring_pkg::out_t
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// Set pixel and ignored commands are handled in the idle state; ring, wheel, clear and breathe
// sweep the frame store one entry per cycle. A tick in a data slot passes through read, shift
// and emit, the shift lasting until the serial bit picker reaches bit position b within the
// pixel (0..23); a tick in a reset slot goes straight to emit. Reset clears per-entry valid bits
// at once, so no clearing pass is needed. A stalled result holds in the output register; only a following tick waits.
module ws2812_ring_frame_driver_core #(
	parameter int PIXELS       = 16,
	parameter int RESET_PIXELS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ws_ring_pkg::in_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ws_ring_pkg::out_t  out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int IDX_W = $clog2(PIXELS);
	localparam int PW    = $clog2(PIXELS + RESET_PIXELS);

	typedef enum logic [1:0] {
		SW_FILL,
		SW_RING,
		SW_WHEEL
	} sw_t;

	ws_ring_pkg::st_t st_q, st_d;

	logic [15:0] high_duty_q, low_duty_q;

	sw_t         sw_kind_q;
	logic [7:0]  n_q, opp_q;
	logic [23:0] color_q;
	logic [IDX_W-1:0] k_q;

	logic [PW-1:0]                 pix_q;
	logic [ws_ring_pkg::BIT_W-1:0] bit_q;
	logic [ws_ring_pkg::BIT_W-1:0] shamt_q;
	logic                          data_slot_q, last_q, hit_q;

	logic [PIXELS-1:0] vld_q;
	logic              rd_vld_q;

	logic        out_valid_q;
	ws_ring_pkg::out_t out_q;

	logic             accept;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [23:0]      ram_wdata, ram_rdata, sweep_data;
	logic             out_load;
	logic             k_last, slot_last, cur_data_slot;
	logic             set_ok, ring_ok, wheel_ok;
	logic [8:0]       ring_sum;

	ws_ring_pkg::bs_req_t bs_req;
	ws_ring_pkg::bs_rsp_t bs_rsp;

	ws_ring_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (pix_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	ws_ring_bitser u_bitser (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bs_req),
		.rsp    (bs_rsp)
	);

	assign accept    = in_valid && !in_stall;
	assign set_ok    = {1'b0, in_data.pixel_index} < 9'(PIXELS);
	assign wheel_ok  = set_ok;
	assign ring_ok   = in_data.pixel_index <= 8'(PIXELS / 2);
	assign k_last    = k_q == IDX_W'(PIXELS - 1);
	assign slot_last = pix_q == PW'(PIXELS + RESET_PIXELS - 1)
		&& bit_q == ws_ring_pkg::BIT_W'(ws_ring_pkg::BPP - 1);
	assign cur_data_slot = {1'b0, pix_q} < (PW + 1)'(PIXELS);
	assign ring_sum  = 9'(k_q) + {1'b0, n_q};

	always_comb begin
		unique case (sw_kind_q)
			SW_RING: sweep_data = (8'(k_q) < n_q || ring_sum >= 9'(PIXELS)) ? color_q : '0;
			SW_WHEEL: sweep_data = (8'(k_q) == n_q || 8'(k_q) == opp_q) ? color_q : '0;
			default: sweep_data = color_q;
		endcase
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ws_ring_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_data.cmd)
						ws_ring_pkg::CMD_RING:    if (ring_ok) st_d = ws_ring_pkg::ST_SWEEP;
						ws_ring_pkg::CMD_WHEEL:   if (wheel_ok) st_d = ws_ring_pkg::ST_SWEEP;
						ws_ring_pkg::CMD_CLEAR,
						ws_ring_pkg::CMD_BREATHE: st_d = ws_ring_pkg::ST_SWEEP;
						ws_ring_pkg::CMD_TICK: begin
							st_d = cur_data_slot ? ws_ring_pkg::ST_READ : ws_ring_pkg::ST_EMIT;
						end
						default: st_d = ws_ring_pkg::ST_IDLE;
					endcase
				end
			end
			ws_ring_pkg::ST_SWEEP: if (k_last) st_d = ws_ring_pkg::ST_IDLE;
			ws_ring_pkg::ST_READ:  st_d = ws_ring_pkg::ST_SHIFT;
			ws_ring_pkg::ST_SHIFT: if (bs_rsp.done) st_d = ws_ring_pkg::ST_EMIT;
			ws_ring_pkg::ST_EMIT:  if (out_load) st_d = ws_ring_pkg::ST_IDLE;
			default: st_d = ws_ring_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		in_stall     = 1'b1;
		ram_we       = 1'b0;
		ram_waddr    = k_q;
		ram_wdata    = sweep_data;
		bs_req.load  = 1'b0;
		bs_req.word  = rd_vld_q ? ram_rdata : '0;
		bs_req.count = shamt_q;
		out_load     = 1'b0;
		unique case (st_q)
			ws_ring_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && in_data.cmd == ws_ring_pkg::CMD_SET && set_ok) begin
					ram_we    = 1'b1;
					ram_waddr = in_data.pixel_index[IDX_W-1:0];
					ram_wdata = in_data.color;
				end
			end
			ws_ring_pkg::ST_SWEEP: ram_we = 1'b1;
			ws_ring_pkg::ST_READ:  bs_req.load = 1'b1;
			ws_ring_pkg::ST_SHIFT: ;
			ws_ring_pkg::ST_EMIT:  out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ws_ring_pkg::ST_IDLE;
			high_duty_q <= 16'd60;
			low_duty_q  <= 16'd30;
			k_q         <= '0;
			pix_q       <= '0;
			bit_q       <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					ws_ring_pkg::REG_HIGH_DUTY: high_duty_q <= cfg_data;
					ws_ring_pkg::REG_LOW_DUTY:  low_duty_q  <= cfg_data;
					default: ;
				endcase
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (st_q == ws_ring_pkg::ST_SWEEP) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end
			if (accept && in_data.cmd == ws_ring_pkg::CMD_TICK) begin
				if (slot_last) begin
					pix_q <= '0;
					bit_q <= '0;
				end else if (bit_q == ws_ring_pkg::BIT_W'(ws_ring_pkg::BPP - 1)) begin
					pix_q <= pix_q + 1'b1;
					bit_q <= '0;
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[pix_q[IDX_W-1:0]];
		if (accept) begin
			n_q   <= in_data.pixel_index;
			opp_q <= (in_data.pixel_index < 8'(PIXELS / 2))
				? in_data.pixel_index + 8'(PIXELS / 2)
				: in_data.pixel_index - 8'(PIXELS / 2);
			priority case (in_data.cmd)
				ws_ring_pkg::CMD_RING: begin
					sw_kind_q <= SW_RING;
					color_q   <= in_data.color;
				end
				ws_ring_pkg::CMD_WHEEL: begin
					sw_kind_q <= SW_WHEEL;
					color_q   <= in_data.color;
				end
				ws_ring_pkg::CMD_BREATHE: begin
					sw_kind_q <= SW_FILL;
					color_q   <= ws_ring_pkg::ramp_color(in_data.level, in_data.channel);
				end
				default: begin
					sw_kind_q <= SW_FILL;
					color_q   <= '0;
				end
			endcase
			shamt_q     <= bit_q;
			data_slot_q <= cur_data_slot;
			last_q      <= slot_last;
		end
		if (bs_rsp.done) begin
			hit_q <= bs_rsp.bit_val;
		end
		if (out_load) begin
			out_q.duty       <= !data_slot_q ? 16'd0 : (hit_q ? high_duty_q : low_duty_q);
			out_q.frame_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// A new result only appears out of the emit state.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> st_q == ws_ring_pkg::ST_EMIT)
		else $error("result loaded outside emit state");

	// The final slot of a frame is always a reset slot.
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_last |-> out_data.duty == 16'd0)
		else $error("frame_last on a slot with nonzero duty");

	// The read state is always followed by the shift state in the next cycle.
	a_read_shift: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ws_ring_pkg::ST_READ |=> st_q == ws_ring_pkg::ST_SHIFT)
		else $error("read state not followed by shift state");

	// Sweep counter stays inside the frame store.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ws_ring_pkg::ST_SWEEP |-> {1'b0, k_q} < (IDX_W + 1)'(PIXELS))
		else $error("sweep index out of range");
`endif

endmodule

/* src/ws_ring_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ws_ring_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/ws_ring_bitser.sv */
// Serial bit picker: shifts a pixel word left one bit per cycle until the wanted bit is on top.
module ws_ring_bitser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ws_ring_pkg::bs_req_t  req,
	output ws_ring_pkg::bs_rsp_t  rsp
);

	logic [ws_ring_pkg::BPP-1:0]   sh_q;
	logic [ws_ring_pkg::BIT_W-1:0] cnt_q;
	logic                          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.load) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			sh_q  <= req.word;
			cnt_q <= req.count;
		end else if (busy_q && cnt_q != '0) begin
			sh_q  <= {sh_q[ws_ring_pkg::BPP-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done    = busy_q && cnt_q == '0;
	assign rsp.bit_val = sh_q[ws_ring_pkg::BPP-1];

endmodule

/* tb/ws_ring_slot_checker.sv */
// Checker for the LED ring frame driver: predicts every tick's slot and compares the results.
module ws_ring_slot_checker #(
	parameter int PIXELS       = 16,
	parameter int RESET_PIXELS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  ws_ring_pkg::in_t  in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  ws_ring_pkg::out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output int                pending,
	output int                errors
);

	localparam int DATA_SLOTS  = PIXELS * ws_ring_pkg::BPP;
	localparam int TOTAL_SLOTS = (PIXELS + RESET_PIXELS) * ws_ring_pkg::BPP;

	logic [23:0]       frame_px [PIXELS];
	int                next_slot;
	logic [15:0]       duty_one;
	logic [15:0]       duty_zero;
	ws_ring_pkg::out_t slot_duty_q [$];
	int                fail_count = 0;

	function automatic logic [23:0] breath_color(input logic [7:0] lvl, input logic [1:0] ch);
		int t;
		int v;
		t = 255 - int'(lvl);
		if (t < 85) begin
			v = 3 * t;
		end else if (t < 170) begin
			v = 255;
		end else begin
			v = 255 - 3 * (t - 170);
		end
		case (ch)
			ws_ring_pkg::CH_GREEN: return {8'(v), 16'd0};
			ws_ring_pkg::CH_BLUE:  return {16'd0, 8'(v)};
			default:               return {8'd0, 8'(v), 8'd0};
		endcase
	endfunction

	// Updates the frame copy for one transaction; returns 1 when a slot result is due.
	function automatic bit predict_command(input ws_ring_pkg::in_t it,
		output ws_ring_pkg::out_t slot_res);
		int idx;
		int opp;
		int s;
		logic [23:0] word;
		idx = int'(it.pixel_index);
		slot_res = '0;
		case (it.cmd)
			ws_ring_pkg::CMD_SET: begin
				if (idx < PIXELS) frame_px[idx] = it.color;
			end
			ws_ring_pkg::CMD_RING: begin
				if (idx <= PIXELS / 2) begin
					for (int k = 0; k < PIXELS; k++)
						frame_px[k] = (k < idx || k >= PIXELS - idx) ? it.color : 24'd0;
				end
			end
			ws_ring_pkg::CMD_WHEEL: begin
				if (idx < PIXELS) begin
					for (int k = 0; k < PIXELS; k++) frame_px[k] = 24'd0;
					opp = (idx < PIXELS / 2) ? idx + PIXELS / 2 : idx - PIXELS / 2;
					frame_px[idx] = it.color;
					if (opp < PIXELS) frame_px[opp] = it.color;
				end
			end
			ws_ring_pkg::CMD_CLEAR: begin
				for (int k = 0; k < PIXELS; k++) frame_px[k] = 24'd0;
			end
			ws_ring_pkg::CMD_BREATHE: begin
				word = breath_color(it.level, it.channel);
				for (int k = 0; k < PIXELS; k++) frame_px[k] = word;
			end
			ws_ring_pkg::CMD_TICK: begin
				s = (next_slot >= TOTAL_SLOTS) ? 0 : next_slot;
				if (s < DATA_SLOTS) begin
					word = frame_px[s / ws_ring_pkg::BPP];
					slot_res.duty = word[23 - (s % ws_ring_pkg::BPP)] ? duty_one : duty_zero;
				end else begin
					slot_res.duty = 16'd0;
				end
				slot_res.frame_last = (s == TOTAL_SLOTS - 1);
				next_slot = slot_res.frame_last ? 0 : s + 1;
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		ws_ring_pkg::out_t want;
		if (!arst_n) begin
			for (int k = 0; k < PIXELS; k++) frame_px[k] = 24'd0;
			next_slot = 0;
			duty_one  = 16'd60;
			duty_zero = 16'd30;
			slot_duty_q.delete();
			pending <= 0;
			errors  <= fail_count;
		end else begin
			// A result leaving at this edge always belongs to an earlier tick.
			if (out_valid && !out_stall) begin
				if (slot_duty_q.size() == 0) begin
					$error("unexpected result: duty %0d, frame_last %0b",
						out_data.duty, out_data.frame_last);
					fail_count++;
				end else begin
					want = slot_duty_q.pop_front();
					if (out_data.duty !== want.duty) begin
						$error("duty: expected %0d, got %0d", want.duty, out_data.duty);
						fail_count++;
					end
					if (out_data.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0b, got %0b",
							want.frame_last, out_data.frame_last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_command(in_data, want)) slot_duty_q.push_back(want);
			end
			if (cfg_we) begin
				if (cfg_index == ws_ring_pkg::REG_HIGH_DUTY) duty_one = cfg_data;
				else duty_zero = cfg_data;
			end
			pending <= slot_duty_q.size();
			errors  <= fail_count;
		end
	end

endmodule

/* tb/tb.sv */
// Testbench top for the LED ring frame driver: clock, reset, stimulus, idling and verdict.
module tb;

	localparam int PIXELS       = 16;
	localparam int RESET_PIXELS = 2;
	localparam int PHASE_ITEMS  = 295;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1000000;

	// Command codes the block treats as no operation.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	ws_ring_pkg::in_t  in_data;
	logic              out_valid;
	logic              out_stall;
	ws_ring_pkg::out_t out_data;
	logic              cfg_we;
	logic              cfg_index;
	logic [15:0]       cfg_data;

	int pending;
	int errors;
	int cycles = 0;
	bit calm = 1'b0;

	ws2812_ring_frame_driver_core #(
		.PIXELS      (PIXELS),
		.RESET_PIXELS(RESET_PIXELS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ws_ring_slot_checker #(
		.PIXELS      (PIXELS),
		.RESET_PIXELS(RESET_PIXELS)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pending  (pending),
		.errors   (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic ws_ring_pkg::in_t pack_cmd(input logic [2:0] cmd, input int idx,
		input logic [23:0] color, input int lvl, input logic [1:0] ch);
		ws_ring_pkg::in_t it;
		it.cmd         = cmd;
		it.pixel_index = 8'(idx);
		it.color       = color;
		it.level       = 8'(lvl);
		it.channel     = ch;
		return it;
	endfunction

	// Mostly ticks so the frame is read back often, with drawing commands mixed in.
	function automatic ws_ring_pkg::in_t rand_item();
		ws_ring_pkg::in_t it;
		int pick;
		it.cmd         = ws_ring_pkg::CMD_TICK;
		it.pixel_index = 8'($urandom);
		it.color       = 24'($urandom);
		it.level       = 8'($urandom);
		it.channel     = 2'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			it.cmd = ws_ring_pkg::CMD_TICK;
		end else if (pick < 80) begin
			it.cmd = ws_ring_pkg::CMD_SET;
			if ($urandom_range(0, 9) != 0) it.pixel_index = 8'($urandom_range(0, PIXELS - 1));
		end else if (pick < 84) begin
			it.cmd = ws_ring_pkg::CMD_RING;
			if ($urandom_range(0, 9) != 0) it.pixel_index = 8'($urandom_range(0, PIXELS / 2));
		end else if (pick < 88) begin
			it.cmd = ws_ring_pkg::CMD_WHEEL;
			if ($urandom_range(0, 9) != 0) it.pixel_index = 8'($urandom_range(0, PIXELS - 1));
		end else if (pick < 90) begin
			it.cmd = ws_ring_pkg::CMD_CLEAR;
		end else if (pick < 97) begin
			it.cmd = ws_ring_pkg::CMD_BREATHE;
		end else begin
			it.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		end
		return it;
	endfunction

	// Presents one transaction, then idles for a drawn gap; valid stays up when the gap is zero.
	task automatic send(input ws_ring_pkg::in_t it);
		int gap;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the sender until every slot result is back and any frame sweep has finished.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_duties(input logic [15:0] one_val, input logic [15:0] zero_val);
		cfg_we    <= 1'b1;
		cfg_index <= ws_ring_pkg::REG_HIGH_DUTY;
		cfg_data  <= one_val;
		@(posedge clk);
		cfg_index <= ws_ring_pkg::REG_LOW_DUTY;
		cfg_data  <= zero_val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_directed();
		send(pack_cmd(ws_ring_pkg::CMD_SET, 0, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_SET, PIXELS - 1, 24'h000001, 255, 2'd3));
		send(pack_cmd(ws_ring_pkg::CMD_SET, PIXELS, 24'hABCDEF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_SET, 255, 24'h123456, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_TICK, 0, 24'd0, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_TICK, 255, 24'hFFFFFF, 255, 2'd3));
		send(pack_cmd(ws_ring_pkg::CMD_RING, PIXELS / 2, 24'h00FF00, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_RING, PIXELS / 2 + 1, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_RING, 255, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_TICK, 0, 24'd0, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_RING, 0, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_WHEEL, 0, 24'h800000, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_WHEEL, PIXELS - 1, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_WHEEL, PIXELS, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_WHEEL, 255, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_CLEAR, 0, 24'd0, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_BREATHE, 0, 24'd0, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_BREATHE, 0, 24'd0, 255, 2'd1));
		send(pack_cmd(ws_ring_pkg::CMD_BREATHE, 0, 24'd0, 170, 2'd2));
		send(pack_cmd(ws_ring_pkg::CMD_BREATHE, 0, 24'd0, 85, 2'd3));
		send(pack_cmd(ws_ring_pkg::CMD_BREATHE, 0, 24'd0, 86, ws_ring_pkg::CH_GREEN));
		send(pack_cmd(CMD_SPARE_6, 3, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(CMD_SPARE_7, 3, 24'hFFFFFF, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_TICK, 0, 24'd0, 0, 2'd0));
		send(pack_cmd(ws_ring_pkg::CMD_SET, 7, 24'h5A5A5A, 0, 2'd0));
	endtask

	initial begin : sink
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = ws_ring_pkg::REG_HIGH_DUTY;
		cfg_data  = 16'd0;
		arst_n    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		repeat (PHASE_ITEMS / 2) send(rand_item());

		for (int phase = 1; phase <= 4; phase++) begin
			settle();
			case (phase)
				1: write_duties(16'hFFFF, 16'h0000);
				2: write_duties(16'h0000, 16'hFFFF);
				3: write_duties(16'($urandom), 16'($urandom));
				default: write_duties(16'($urandom_range(1, 255)), 16'($urandom_range(1, 255)));
			endcase
			calm = (phase == 2);
			repeat (PHASE_ITEMS) send(rand_item());
		end
		calm = 1'b0;

		settle();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
